FILE: sv/pmacc_pkg.sv
// ---------------------------------------------------------------------------
// pmacc_pkg: shared types and helpers for the per-point moment accumulator
// Command codes, the queued command format, sum slot numbering, saturation.
// ---------------------------------------------------------------------------
package pmacc_pkg;

   localparam int NSUMS      = 22;
   localparam int POINTS_DEF = 4096;
   localparam int CMDQ_DEPTH = 2;
   localparam int RSP_DEPTH  = 4;
   localparam int PT_LIMIT_W = 21;   // holds any POINTS up to 2^20

   // sum slots
   localparam int SUM_U   = 0;
   localparam int SUM_V   = 1;
   localparam int SUM_W   = 2;
   localparam int SUM_T   = 3;
   localparam int SUM_UU  = 4;
   localparam int SUM_VV  = 5;
   localparam int SUM_WW  = 6;
   localparam int SUM_UV  = 7;
   localparam int SUM_VW  = 8;
   localparam int SUM_WU  = 9;
   localparam int SUM_TT  = 10;
   localparam int SUM_TU  = 11;
   localparam int SUM_TV  = 12;
   localparam int SUM_TW  = 13;
   localparam int SUM_UUU = 14;
   localparam int SUM_VVV = 15;
   localparam int SUM_WWW = 16;
   localparam int SUM_TTT = 17;
   localparam int SUM_UUW = 18;
   localparam int SUM_VVW = 19;
   localparam int SUM_S   = 20;
   localparam int SUM_SS  = 21;

   localparam logic [15:0] FRAMES_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      OP_ACC  = 2'd0,
      OP_CLR  = 2'd1,
      OP_READ = 2'd2,
      OP_NOP  = 2'd3
   } op_type;

   typedef logic [NSUMS-1:0][63:0] row_type;

   typedef struct packed {
      op_type             op;
      logic [11:0]        point;
      logic               in_range;
      logic               pt_zero;
      logic               frame_start;
      logic signed [15:0] u;
      logic signed [15:0] v;
      logic signed [15:0] w;
      logic signed [15:0] t;
      logic signed [15:0] s;
      logic [4:0]         sel;
      logic               sel_ok;
   } cmd_type;

   function automatic logic [63:0] sx16(input logic [15:0] x);
      return {{48{x[15]}}, x};
   endfunction

   function automatic logic [63:0] sx32(input logic [31:0] x);
      return {{32{x[31]}}, x};
   endfunction

   function automatic logic [63:0] sx48(input logic [47:0] x);
      return {{16{x[47]}}, x};
   endfunction

   // two's complement add clamped to the signed 64-bit range
   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if ((a[63] == b[63]) && (s[63] != a[63]))
         s = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      return s;
   endfunction

endpackage

FILE: sv/per_point_moment_accumulator_core.sv
// ---------------------------------------------------------------------------
// per_point_moment_accumulator_core: running moment sums per grid point
// Keeps 22 saturating 64-bit sums for each point plus a frame counter.
// ---------------------------------------------------------------------------
// One request item is taken per clock while req_tready is high (accumulate, clear or read), and
// consecutive items may hit the same point: a four-stage pipeline (row read,
// 16x16 products, cube products, saturating add and write) forwards its
// last three row writes so every item sees the sums left by the one before.
// A read raises rsp_tvalid once its item has passed the command queue, the
// pipeline and the response buffer; accumulate, clear and unused codes
// yield none. Reads are only issued while
// the four-entry response buffer has room, so a stalled response side holds
// back reads but not the request intake until the two-entry command queue
// fills. After reset a clearing pass zeroes the row memory, one point per
// cycle: req_tready stays low until every point has been cleared.
// ---------------------------------------------------------------------------
module per_point_moment_accumulator_core #(
   parameter int POINTS = pmacc_pkg::POINTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [11:0] point_index, [27:12] vel_x, [43:28] vel_y, [59:44] vel_z,
   // [75:60] temperature, [91:76] scalar_value, [95:92] zero
   input  logic [95:0] req_tdata,
   // [1:0] operation, [2] frame_start, [7:3] moment_select
   input  logic [7:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [63:0] sum_value, [79:64] frames_summed
   output logic [79:0] rsp_tdata
);
   logic               clearing;
   logic               cmd_valid;
   logic               cmd_pop;
   pmacc_pkg::cmd_type cmd;
   logic               rsp_push;
   logic [79:0]        rsp_data;
   logic [$clog2(pmacc_pkg::RSP_DEPTH):0] rsp_count;

   // intake and decode
   pma_front #(.POINTS(POINTS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .clearing   (clearing),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   // sums memory and update pipeline
   pma_back #(.POINTS(POINTS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .clearing  (clearing),
      .rsp_count (rsp_count),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_data)
   );

   // response buffer decouples the read path from rsp_tready
   pma_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (rsp_push),
      .push_data  (rsp_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .count      (rsp_count)
   );

endmodule

FILE: sv/pma_front.sv
// ---------------------------------------------------------------------------
// pma_front: request intake
// Decodes request items into commands and holds them in a short queue.
// ---------------------------------------------------------------------------
module pma_front #(
   parameter int POINTS = pmacc_pkg::POINTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [95:0]        req_tdata,
   input  logic [7:0]         req_tuser,
   input  logic               clearing,
   output logic               cmd_valid,
   output pmacc_pkg::cmd_type cmd,
   input  logic               cmd_pop
);
   localparam int QD = pmacc_pkg::CMDQ_DEPTH;
   localparam int QW = $clog2(QD);
   localparam logic [pmacc_pkg::PT_LIMIT_W-1:0] PT_LIMIT =
      pmacc_pkg::PT_LIMIT_W'(POINTS);

   pmacc_pkg::cmd_type q_ff [QD];
   logic [QW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QW:0]   count_ff, count_in;
   pmacc_pkg::cmd_type dec;
   logic push;

   always_comb begin
      dec.op          = pmacc_pkg::op_type'(req_tuser[1:0]);
      dec.frame_start = req_tuser[2];
      dec.sel         = req_tuser[7:3];
      dec.point       = req_tdata[11:0];
      dec.u           = req_tdata[27:12];
      dec.v           = req_tdata[43:28];
      dec.w           = req_tdata[59:44];
      dec.t           = req_tdata[75:60];
      dec.s           = req_tdata[91:76];
      dec.in_range    = pmacc_pkg::PT_LIMIT_W'(req_tdata[11:0]) < PT_LIMIT;
      dec.pt_zero     = req_tdata[11:0] == 12'd0;
      dec.sel_ok      = req_tuser[7:3] < 5'(pmacc_pkg::NSUMS);
   end

   assign req_tready = (count_ff != (QW+1)'(QD)) && !clearing;
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = count_ff != '0;
   assign cmd        = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push    ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QW+1)'(push) - (QW+1)'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= dec;
   end

endmodule

FILE: sv/pma_rsp_queue.sv
// ---------------------------------------------------------------------------
// pma_rsp_queue: result buffer
// Holds read results until the response side takes them.
// ---------------------------------------------------------------------------
module pma_rsp_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic [79:0] push_data,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,
   output logic [$clog2(pmacc_pkg::RSP_DEPTH):0] count
);
   localparam int D  = pmacc_pkg::RSP_DEPTH;
   localparam int AW = $clog2(D);

   logic [79:0]   q_ff [D];
   logic [AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [AW:0]   count_ff, count_in;
   logic pop;

   assign rsp_tvalid = count_ff != '0;
   assign rsp_tdata  = q_ff[rd_ptr_ff];
   assign pop        = rsp_tvalid && rsp_tready;
   assign count      = count_ff;
   assign count_in   = count_ff + (AW+1)'(push) - (AW+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= push_data;
   end

endmodule

FILE: sv/pma_back.sv
// ---------------------------------------------------------------------------
// pma_back: execution pipeline
// Row read, products, cubes, saturating update and write back, with bypass.
// ---------------------------------------------------------------------------
module pma_back #(
   parameter int POINTS = pmacc_pkg::POINTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  pmacc_pkg::cmd_type cmd,
   output logic               cmd_pop,
   output logic               clearing,
   input  logic [$clog2(pmacc_pkg::RSP_DEPTH):0] rsp_count,
   output logic               rsp_push,
   output logic [79:0]        rsp_data
);
   localparam int AW = (POINTS > 1) ? $clog2(POINTS) : 1;
   localparam int CW = $clog2(pmacc_pkg::RSP_DEPTH) + 2;
   localparam int NB = 3;   // writes that land after a row read

   // row memory
   pmacc_pkg::row_type mem [POINTS];
   pmacc_pkg::row_type rd_row_ff;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   pmacc_pkg::row_type wr_row;

   // clearing pass
   logic          clr_ff, clr_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;

   // pipe stages
   logic p1_v_ff, p2_v_ff, p3_v_ff;
   pmacc_pkg::cmd_type p1_ff, p2_ff, p3_ff;
   pmacc_pkg::row_type row2_ff, row3_ff, inc_ff, inc_in;
   logic signed [31:0] uu_ff, vv_ff, ww_ff, uv_ff, vw_ff, wu_ff;
   logic signed [31:0] tt_ff, tu_ff, tv_ff, tw_ff, ss_ff;

   // bypass of recent writes, index 0 newest
   logic               bp_v_ff   [NB];
   logic [AW-1:0]      bp_addr_ff[NB];
   pmacc_pkg::row_type bp_row_ff [NB];

   logic [15:0] frames_ff, frames_in;
   logic [CW-1:0] reads_pending;
   logic issue_ok;
   logic [AW-1:0] p3_addr;
   pmacc_pkg::row_type old_row;
   logic p3_write;

   assign clearing = clr_ff;

   // results in flight must all fit the result buffer
   assign reads_pending = CW'(rsp_count)
                        + CW'(p1_v_ff && p1_ff.op == pmacc_pkg::OP_READ)
                        + CW'(p2_v_ff && p2_ff.op == pmacc_pkg::OP_READ)
                        + CW'(p3_v_ff && p3_ff.op == pmacc_pkg::OP_READ);
   assign issue_ok = (cmd.op != pmacc_pkg::OP_READ)
                   || (reads_pending < CW'(pmacc_pkg::RSP_DEPTH));
   assign cmd_pop  = cmd_valid && !clr_ff && issue_ok;

   always_comb begin
      clr_in     = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clr_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == AW'(POINTS - 1)) clr_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
      end else begin
         clr_ff     <= clr_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_row;
      rd_row_ff <= mem[AW'(cmd.point)];
   end

   // stage 2 inputs: cubes from registered products
   always_comb begin
      logic signed [47:0] uuu, vvv, www, ttt, uuw, vvw;
      uuu = uu_ff * p2_ff.u;
      vvv = vv_ff * p2_ff.v;
      www = ww_ff * p2_ff.w;
      ttt = tt_ff * p2_ff.t;
      uuw = uu_ff * p2_ff.w;
      vvw = vv_ff * p2_ff.w;
      inc_in[pmacc_pkg::SUM_U]   = pmacc_pkg::sx16(p2_ff.u);
      inc_in[pmacc_pkg::SUM_V]   = pmacc_pkg::sx16(p2_ff.v);
      inc_in[pmacc_pkg::SUM_W]   = pmacc_pkg::sx16(p2_ff.w);
      inc_in[pmacc_pkg::SUM_T]   = pmacc_pkg::sx16(p2_ff.t);
      inc_in[pmacc_pkg::SUM_UU]  = pmacc_pkg::sx32(uu_ff);
      inc_in[pmacc_pkg::SUM_VV]  = pmacc_pkg::sx32(vv_ff);
      inc_in[pmacc_pkg::SUM_WW]  = pmacc_pkg::sx32(ww_ff);
      inc_in[pmacc_pkg::SUM_UV]  = pmacc_pkg::sx32(uv_ff);
      inc_in[pmacc_pkg::SUM_VW]  = pmacc_pkg::sx32(vw_ff);
      inc_in[pmacc_pkg::SUM_WU]  = pmacc_pkg::sx32(wu_ff);
      inc_in[pmacc_pkg::SUM_TT]  = pmacc_pkg::sx32(tt_ff);
      inc_in[pmacc_pkg::SUM_TU]  = pmacc_pkg::sx32(tu_ff);
      inc_in[pmacc_pkg::SUM_TV]  = pmacc_pkg::sx32(tv_ff);
      inc_in[pmacc_pkg::SUM_TW]  = pmacc_pkg::sx32(tw_ff);
      inc_in[pmacc_pkg::SUM_UUU] = pmacc_pkg::sx48(uuu);
      inc_in[pmacc_pkg::SUM_VVV] = pmacc_pkg::sx48(vvv);
      inc_in[pmacc_pkg::SUM_WWW] = pmacc_pkg::sx48(www);
      inc_in[pmacc_pkg::SUM_TTT] = pmacc_pkg::sx48(ttt);
      inc_in[pmacc_pkg::SUM_UUW] = pmacc_pkg::sx48(uuw);
      inc_in[pmacc_pkg::SUM_VVW] = pmacc_pkg::sx48(vvw);
      inc_in[pmacc_pkg::SUM_S]   = pmacc_pkg::sx16(p2_ff.s);
      inc_in[pmacc_pkg::SUM_SS]  = pmacc_pkg::sx32(ss_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
      end else begin
         p1_v_ff <= cmd_pop;
         p2_v_ff <= p1_v_ff;
         p3_v_ff <= p2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff   <= cmd;
      p2_ff   <= p1_ff;
      p3_ff   <= p2_ff;
      row2_ff <= rd_row_ff;
      row3_ff <= row2_ff;
      uu_ff   <= p1_ff.u * p1_ff.u;
      vv_ff   <= p1_ff.v * p1_ff.v;
      ww_ff   <= p1_ff.w * p1_ff.w;
      uv_ff   <= p1_ff.u * p1_ff.v;
      vw_ff   <= p1_ff.v * p1_ff.w;
      wu_ff   <= p1_ff.w * p1_ff.u;
      tt_ff   <= p1_ff.t * p1_ff.t;
      tu_ff   <= p1_ff.t * p1_ff.u;
      tv_ff   <= p1_ff.t * p1_ff.v;
      tw_ff   <= p1_ff.t * p1_ff.w;
      ss_ff   <= p1_ff.s * p1_ff.s;
      inc_ff  <= inc_in;
   end

   // stage 3: newest matching write wins over the row read
   assign p3_addr = AW'(p3_ff.point);

   always_comb begin
      old_row = row3_ff;
      priority if (bp_v_ff[0] && bp_addr_ff[0] == p3_addr) old_row = bp_row_ff[0];
      else if (bp_v_ff[1] && bp_addr_ff[1] == p3_addr)    old_row = bp_row_ff[1];
      else if (bp_v_ff[2] && bp_addr_ff[2] == p3_addr)    old_row = bp_row_ff[2];
      else                                                 old_row = row3_ff;
   end

   assign p3_write = p3_v_ff && p3_ff.in_range
                   && (p3_ff.op == pmacc_pkg::OP_ACC || p3_ff.op == pmacc_pkg::OP_CLR);

   always_comb begin
      wr_en   = clr_ff || p3_write;
      wr_addr = clr_ff ? clr_cnt_ff : p3_addr;
      wr_row  = '0;
      if (!clr_ff && p3_ff.op == pmacc_pkg::OP_ACC) begin
         for (int k = 0; k < pmacc_pkg::NSUMS; k++)
            wr_row[k] = pmacc_pkg::sat_add(old_row[k], inc_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NB; i++) bp_v_ff[i] <= 1'b0;
      end else begin
         bp_v_ff[0] <= p3_write;
         for (int i = 1; i < NB; i++) bp_v_ff[i] <= bp_v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      bp_addr_ff[0] <= p3_addr;
      bp_row_ff[0]  <= wr_row;
      for (int i = 1; i < NB; i++) begin
         bp_addr_ff[i] <= bp_addr_ff[i-1];
         bp_row_ff[i]  <= bp_row_ff[i-1];
      end
   end

   // frame count follows command order at stage 3
   always_comb begin
      frames_in = frames_ff;
      if (p3_v_ff) begin
         unique case (p3_ff.op)
            pmacc_pkg::OP_ACC:
               if (p3_ff.frame_start && frames_ff != pmacc_pkg::FRAMES_MAX)
                  frames_in = frames_ff + 16'd1;
            pmacc_pkg::OP_CLR:
               if (p3_ff.pt_zero) frames_in = '0;
            pmacc_pkg::OP_READ, pmacc_pkg::OP_NOP: frames_in = frames_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) frames_ff <= '0;
      else       frames_ff <= frames_in;
   end

   assign rsp_push = p3_v_ff && p3_ff.op == pmacc_pkg::OP_READ;
   assign rsp_data = {frames_ff,
                      (p3_ff.in_range && p3_ff.sel_ok) ? old_row[p3_ff.sel] : 64'd0};

endmodule

FILE: sv/pma_checker.sv
// ---------------------------------------------------------------------------
// pma_checker: port-level checks
// Reset behavior, clearing pass and response stability.
// ---------------------------------------------------------------------------
module pma_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata
);
   // no response is left over from before reset
   a_rst_rsp : assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // the clearing pass holds off requests right after reset
   a_rst_clr : assert property (@(posedge clock) $fell(reset) |-> !req_tready)
      else $error("request taken during clearing pass");

   // a waiting response keeps its data
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed while stalled");

endmodule

bind per_point_moment_accumulator_core pma_checker u_pma_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
